[sv/skm_pkg.sv]
// skyline merge engine package
// control and status bundles shared by the top level and the merge scheduler
// depends on nothing
package skm_pkg;

    typedef struct packed {
        logic start;     // begin walking the split tree of a loaded group
        logic ack;       // merge of the offered range has been written back
    } skm_sched_ctrl_t;

    typedef struct packed {
        logic range_valid;  // a merge range is offered
        logic done;         // every merge of the group has been offered
    } skm_sched_status_t;

    localparam int HEIGHT_BITS = 16;
    localparam int PORT_BITS   = 16;

endpackage

[sv/skyline_merge_engine_top.sv]
// skyline merge engine top level
// point memory, merge scratch memory, merge and emit sequencer, output register
// depends on skm_pkg and skm_sched
//
//   channel  signals                                              role
//   in       in_valid in_ready building_left building_right       one building per
//            building_height last_building                        transfer
//   out      out_valid out_ready point_x point_height             one skyline key
//            last_point overflow                                  point per transfer
//
// each building is loaded in T_IDLE and then T_LOAD2: the point memory has one write port and
// each building lays down its two key points (left, height) and (right, 0)
// the building marked last starts the merges; each merge reads and then
// writes scratch for each point it merges and then copies each point back;
// once every merge is done, an output scan walks the points in order
// the memories need no clearing after reset: only written entries are read
// the input is refused from the last building until the final point is
// handed to the output register; the output register stalls the scan only
module skyline_merge_engine_top
    import skm_pkg::*;
#(
    parameter int MAX_BUILDINGS = 16,
    parameter int COORD_BITS    = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PORT_BITS-1:0]   building_left,
    input  logic [PORT_BITS-1:0]   building_right,
    input  logic [HEIGHT_BITS-1:0] building_height,
    input  logic                   last_building,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PORT_BITS-1:0]   point_x,
    output logic [HEIGHT_BITS-1:0] point_height,
    output logic                   last_point,
    output logic                   overflow
);

    // stored x width: ports carry 16 bits, COORD_BITS may mask further
    localparam int XW   = (COORD_BITS < PORT_BITS) ? COORD_BITS : PORT_BITS;
    localparam int PTW  = XW + HEIGHT_BITS;
    localparam int BW   = $clog2(MAX_BUILDINGS + 1);
    localparam int PCW  = $clog2(2 * MAX_BUILDINGS + 1);
    localparam int PW   = $clog2(2 * MAX_BUILDINGS);
    localparam int PDEP = 2 * MAX_BUILDINGS;

    typedef enum logic [3:0] {
        T_IDLE, T_LOAD2, T_SCHED, T_MREQ, T_MOUT, T_CREQ, T_COUT,
        T_EREQ, T_ECHK, T_FLUSH
    } tstate_t;

    tstate_t                state_reg;
    logic [BW-1:0]          cnt_reg;
    logic                   ovf_reg;
    logic                   last_reg;
    logic [XW-1:0]          right_reg;

    // merge pointers: i and j also drive the two point memory read ports
    logic [PCW-1:0]         i_reg;
    logic [PCW-1:0]         j_reg;
    logic [PCW-1:0]         k_reg;
    logic [PCW-1:0]         a_reg;
    logic [PCW-1:0]         m_reg;
    logic [PCW-1:0]         e_reg;
    logic [HEIGHT_BITS-1:0] h1_reg;
    logic [HEIGHT_BITS-1:0] h2_reg;

    // emit scan: last kept height and one pending point held back for last_point
    logic [HEIGHT_BITS-1:0] lasth_reg;
    logic                   pend_v_reg;
    logic [PTW-1:0]         pend_reg;

    logic                   out_valid_reg;
    logic [PORT_BITS-1:0]   out_x_reg;
    logic [HEIGHT_BITS-1:0] out_h_reg;
    logic                   out_last_reg;
    logic                   out_ovf_reg;

    // memories
    logic [PTW-1:0]         pmem [PDEP];
    logic [PTW-1:0]         tmem [PDEP];
    logic [PTW-1:0]         rd_a;
    logic [PTW-1:0]         rd_b;
    logic [PTW-1:0]         trd;
    logic                   pw_en;
    logic [PW-1:0]          pw_addr;
    logic [PTW-1:0]         pw_data;
    logic                   tw_en;
    logic [PTW-1:0]         tw_data;

    skm_sched_ctrl_t        sctrl;
    skm_sched_status_t      sstat;
    logic [PCW-1:0]         r_a;
    logic [PCW-1:0]         r_m;
    logic [PCW-1:0]         r_e;
    logic [BW-1:0]          sched_cnt;

    logic                   in_fire;
    logic                   has_room;
    logic [PCW-1:0]         two_cnt;
    logic [PCW-1:0]         total;
    logic [PCW-1:0]         k_inc;

    // merge step decode
    logic [XW-1:0]          xa;
    logic [XW-1:0]          xb;
    logic [HEIGHT_BITS-1:0] ha;
    logic [HEIGHT_BITS-1:0] hb;
    logic                   a_left;
    logic                   b_left;
    logic                   take_a;
    logic [HEIGHT_BITS-1:0] h1_next;
    logic [HEIGHT_BITS-1:0] h2_next;
    logic [XW-1:0]          mx;
    logic [HEIGHT_BITS-1:0] mh;

    assign in_ready = (state_reg == T_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign has_room = (cnt_reg < BW'(MAX_BUILDINGS));
    assign two_cnt  = PCW'({cnt_reg, 1'b0});
    assign total    = e_reg - a_reg;
    assign k_inc    = k_reg + PCW'(1);

    assign out_valid    = out_valid_reg;
    assign point_x      = out_x_reg;
    assign point_height = out_h_reg;
    assign last_point   = out_last_reg;
    assign overflow     = out_ovf_reg;

    // the count only steps at the end of T_LOAD2, so the scheduler sees it one ahead there
    assign sched_cnt = (state_reg == T_LOAD2) ? BW'(cnt_reg + BW'(1)) : cnt_reg;

    skm_sched #(
        .MAX_BUILDINGS (MAX_BUILDINGS)
    ) u_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sctrl),
        .count   (sched_cnt),
        .status  (sstat),
        .range_a (r_a),
        .range_m (r_m),
        .range_e (r_e)
    );

    // the group starts once the last building's points are in memory
    assign sctrl.start = (state_reg == T_LOAD2 && last_reg)
                      || (state_reg == T_IDLE && in_fire && !has_room && last_building);
    assign sctrl.ack   = (state_reg == T_COUT) && (k_inc == total);

    // merge: smaller x from the left list, ties go to the right list;
    // once a list runs out the other is copied with its own heights
    assign xa     = rd_a[PTW-1:HEIGHT_BITS];
    assign ha     = rd_a[HEIGHT_BITS-1:0];
    assign xb     = rd_b[PTW-1:HEIGHT_BITS];
    assign hb     = rd_b[HEIGHT_BITS-1:0];
    assign a_left = (i_reg < m_reg);
    assign b_left = (j_reg < e_reg);

    always_comb
    begin
        take_a  = a_left && (!b_left || (xa < xb));
        h1_next = h1_reg;
        h2_next = h2_reg;
        if (a_left && b_left)
        begin
            if (take_a)
            begin
                h1_next = ha;
            end
            else
            begin
                h2_next = hb;
            end
            mh = (h1_next > h2_next) ? h1_next : h2_next;
        end
        else
        begin
            mh = take_a ? ha : hb;
        end
        mx = take_a ? xa : xb;
    end

    assign tw_en   = (state_reg == T_MOUT);
    assign tw_data = {mx, mh};

    // single write port of the point memory
    always_comb
    begin
        pw_en   = 1'b0;
        pw_addr = PW'(two_cnt);
        pw_data = {building_left[XW-1:0], building_height};
        case (state_reg)
            T_IDLE:
            begin
                pw_en = in_fire && has_room;
            end
            T_LOAD2:
            begin
                pw_en   = 1'b1;
                pw_addr = PW'(two_cnt + PCW'(1));
                pw_data = {right_reg, {HEIGHT_BITS{1'b0}}};
            end
            T_COUT:
            begin
                pw_en   = 1'b1;
                pw_addr = PW'(a_reg + k_reg);
                pw_data = trd;
            end
            default:
            begin
                pw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            pmem[pw_addr] <= pw_data;
        end
        rd_a <= pmem[PW'(i_reg)];
        rd_b <= pmem[PW'(j_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            tmem[PW'(k_reg)] <= tw_data;
        end
        trd <= tmem[PW'(k_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            right_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            a_reg         <= '0;
            m_reg         <= '0;
            e_reg         <= '0;
            h1_reg        <= '0;
            h2_reg        <= '0;
            lasth_reg     <= '0;
            pend_reg      <= '0;
            out_x_reg     <= '0;
            out_h_reg     <= '0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            // output transfer frees the register; a new load below wins
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (in_fire)
                    begin
                        last_reg  <= last_building;
                        right_reg <= building_right[XW-1:0];
                        if (has_room)
                        begin
                            state_reg <= T_LOAD2;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                            if (last_building)
                            begin
                                state_reg <= T_SCHED;
                            end
                        end
                    end
                end
                T_LOAD2:
                begin
                    cnt_reg   <= cnt_reg + BW'(1);
                    state_reg <= last_reg ? T_SCHED : T_IDLE;
                end
                T_SCHED:
                begin
                    if (sstat.range_valid)
                    begin
                        a_reg     <= r_a;
                        m_reg     <= r_m;
                        e_reg     <= r_e;
                        i_reg     <= r_a;
                        j_reg     <= r_m;
                        k_reg     <= '0;
                        h1_reg    <= '0;
                        h2_reg    <= '0;
                        state_reg <= T_MREQ;
                    end
                    else if (sstat.done)
                    begin
                        i_reg      <= '0;
                        lasth_reg  <= '0;
                        pend_v_reg <= 1'b0;
                        state_reg  <= T_EREQ;
                    end
                end
                T_MREQ:
                begin
                    state_reg <= T_MOUT;
                end
                T_MOUT:
                begin
                    h1_reg <= h1_next;
                    h2_reg <= h2_next;
                    if (take_a)
                    begin
                        i_reg <= i_reg + PCW'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + PCW'(1);
                    end
                    if (k_inc == total)
                    begin
                        k_reg     <= '0;
                        state_reg <= T_CREQ;
                    end
                    else
                    begin
                        k_reg     <= k_inc;
                        state_reg <= T_MREQ;
                    end
                end
                T_CREQ:
                begin
                    state_reg <= T_COUT;
                end
                T_COUT:
                begin
                    k_reg     <= k_inc;
                    state_reg <= (k_inc == total) ? T_SCHED : T_CREQ;
                end
                T_EREQ:
                begin
                    state_reg <= (i_reg == two_cnt) ? T_FLUSH : T_ECHK;
                end
                T_ECHK:
                begin
                    if (ha == lasth_reg)
                    begin
                        i_reg     <= i_reg + PCW'(1);
                        state_reg <= T_EREQ;
                    end
                    else if (!(pend_v_reg && out_valid_reg))
                    begin
                        if (pend_v_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_x_reg     <= PORT_BITS'(pend_reg[PTW-1:HEIGHT_BITS]);
                            out_h_reg     <= pend_reg[HEIGHT_BITS-1:0];
                            out_last_reg  <= 1'b0;
                            out_ovf_reg   <= ovf_reg;
                        end
                        pend_v_reg <= 1'b1;
                        pend_reg   <= rd_a;
                        lasth_reg  <= ha;
                        i_reg      <= i_reg + PCW'(1);
                        state_reg  <= T_EREQ;
                    end
                end
                T_FLUSH:
                begin
                    if (!pend_v_reg || !out_valid_reg)
                    begin
                        if (pend_v_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_x_reg     <= PORT_BITS'(pend_reg[PTW-1:HEIGHT_BITS]);
                            out_h_reg     <= pend_reg[HEIGHT_BITS-1:0];
                            out_last_reg  <= 1'b1;
                            out_ovf_reg   <= ovf_reg;
                        end
                        pend_v_reg <= 1'b0;
                        cnt_reg    <= '0;
                        ovf_reg    <= 1'b0;
                        lasth_reg  <= '0;
                        state_reg  <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/skm_sched.sv]
// skyline merge engine: merge scheduler
// walks the (lo + hi) / 2 split tree in post order with a small stack
// depends on skm_pkg
module skm_sched
    import skm_pkg::*;
#(
    parameter int MAX_BUILDINGS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  skm_sched_ctrl_t                      ctrl,
    input  logic [$clog2(MAX_BUILDINGS+1)-1:0]   count,
    output skm_sched_status_t                    status,
    output logic [$clog2(2*MAX_BUILDINGS+1)-1:0] range_a,
    output logic [$clog2(2*MAX_BUILDINGS+1)-1:0] range_m,
    output logic [$clog2(2*MAX_BUILDINGS+1)-1:0] range_e
);

    localparam int BW  = $clog2(MAX_BUILDINGS + 1);
    localparam int PCW = $clog2(2 * MAX_BUILDINGS + 1);
    localparam int SD  = $clog2(MAX_BUILDINGS) + 2;
    localparam int SPW = $clog2(SD + 1);
    localparam int SIW = $clog2(SD);

    localparam logic [1:0] STG_LEFT  = 2'd0;
    localparam logic [1:0] STG_RIGHT = 2'd1;
    localparam logic [1:0] STG_MERGE = 2'd2;

    typedef enum logic [1:0] {S_IDLE, S_STEP, S_WAIT} state_t;

    state_t           state_reg;
    logic [SPW-1:0]   sp_reg;
    logic [BW-1:0]    lo_stk [SD];
    logic [BW-1:0]    hi_stk [SD];
    logic [1:0]       stg_stk [SD];

    logic [SIW-1:0]   top_ix;
    logic [SIW-1:0]   push_ix;
    logic [BW-1:0]    top_lo;
    logic [BW-1:0]    top_hi;
    logic [1:0]       top_stg;
    logic [BW-1:0]    mid;
    logic             push_en;
    logic [BW-1:0]    push_lo;
    logic [BW-1:0]    push_hi;
    logic             stg_en;
    logic [1:0]       stg_val;

    assign top_ix  = SIW'(sp_reg - SPW'(1));
    assign push_ix = SIW'(sp_reg);
    assign top_lo  = lo_stk[top_ix];
    assign top_hi  = hi_stk[top_ix];
    assign top_stg = stg_stk[top_ix];
    assign mid     = BW'(({1'b0, top_lo} + {1'b0, top_hi}) >> 1);

    assign range_a = PCW'({top_lo, 1'b0});
    assign range_m = PCW'({mid, 1'b0}) + PCW'(2);
    assign range_e = PCW'({top_hi, 1'b0}) + PCW'(2);

    assign status.range_valid = (state_reg == S_WAIT);
    assign status.done        = (state_reg == S_STEP) && (sp_reg == '0);

    always_comb
    begin
        push_en = 1'b0;
        push_lo = '0;
        push_hi = '0;
        stg_en  = 1'b0;
        stg_val = STG_LEFT;
        if (state_reg == S_IDLE && ctrl.start)
        begin
            push_en = 1'b1;
            push_hi = BW'(count - BW'(1));
        end
        else if (state_reg == S_STEP && sp_reg != '0 && top_lo != top_hi)
        begin
            case (top_stg)
                STG_LEFT:
                begin
                    push_en = 1'b1;
                    push_lo = top_lo;
                    push_hi = mid;
                    stg_en  = 1'b1;
                    stg_val = STG_RIGHT;
                end
                STG_RIGHT:
                begin
                    push_en = 1'b1;
                    push_lo = BW'(mid + BW'(1));
                    push_hi = top_hi;
                    stg_en  = 1'b1;
                    stg_val = STG_MERGE;
                end
                default:
                begin
                    push_en = 1'b0;
                end
            endcase
        end
    end

    // stack entries hold payload only
    always_ff @(posedge clk)
    begin
        if (stg_en)
        begin
            stg_stk[top_ix] <= stg_val;
        end
        if (push_en)
        begin
            lo_stk[push_ix]  <= push_lo;
            hi_stk[push_ix]  <= push_hi;
            stg_stk[push_ix] <= STG_LEFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        sp_reg    <= SPW'(1);
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (sp_reg == '0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (top_lo == top_hi)
                    begin
                        sp_reg <= sp_reg - SPW'(1);
                    end
                    else if (top_stg == STG_LEFT || top_stg == STG_RIGHT)
                    begin
                        sp_reg <= sp_reg + SPW'(1);
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (ctrl.ack)
                    begin
                        sp_reg    <= sp_reg - SPW'(1);
                        state_reg <= S_STEP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[verif/skyline_merge_engine_top_test.sv]
// self-checking testbench for skyline_merge_engine_top
// drives building groups, predicts skyline key points and checks every point transfer
// depends on skm_pkg and the skyline_merge_engine_top rtl
`timescale 1ns / 100ps

// predicts skyline points per building group and checks the ones the block emits
class skyline_scoreboard;
    typedef struct {
        bit [15:0] x;
        bit [15:0] h;
        bit        last;
        bit        ovf;
    } key_point_t;

    bit [15:0]  bld_left[16];
    bit [15:0]  bld_right[16];
    bit [15:0]  bld_height[16];
    int         bld_count;
    bit         ovf_seen;
    bit [15:0]  pt_x[64];
    bit [15:0]  pt_h[64];
    key_point_t skyline_q[$];
    int         errors;
    int         points_checked;
    int         groups_done;
    int         overflow_groups;

    function int pending();
        return skyline_q.size();
    endfunction

    // merge [a, m) with [m, e); ties take the right list
    function void merge_points(int a, int m, int e);
        bit [15:0] tx[64];
        bit [15:0] th[64];
        bit [15:0] h1;
        bit [15:0] h2;
        int i;
        int j;
        int k;
        i = a; j = m; k = 0; h1 = 0; h2 = 0;
        while (i < m && j < e) begin
            if (pt_x[i] < pt_x[j]) begin
                h1 = pt_h[i];
                tx[k] = pt_x[i];
                i++;
            end
            else begin
                h2 = pt_h[j];
                tx[k] = pt_x[j];
                j++;
            end
            th[k] = (h1 > h2) ? h1 : h2;
            k++;
        end
        while (i < m) begin tx[k] = pt_x[i]; th[k] = pt_h[i]; i++; k++; end
        while (j < e) begin tx[k] = pt_x[j]; th[k] = pt_h[j]; j++; k++; end
        for (int n = 0; n < k; n++)
        begin
            pt_x[a+n] = tx[n];
            pt_h[a+n] = th[n];
        end
    endfunction

    function void build_tree(int lo, int hi);
        int mid;
        if (lo == hi)
        begin
            pt_x[2*lo]   = bld_left[lo];
            pt_h[2*lo]   = bld_height[lo];
            pt_x[2*lo+1] = bld_right[lo];
            pt_h[2*lo+1] = 0;
            return;
        end
        mid = (lo + hi) / 2;
        build_tree(lo, mid);
        build_tree(mid + 1, hi);
        merge_points(2*lo, 2*mid + 2, 2*hi + 2);
    endfunction

    function void note_building(bit [15:0] l, bit [15:0] r, bit [15:0] h, bit last);
        key_point_t kp;
        bit [15:0]  prev_h;
        int         first_new;
        if (bld_count < 16)
        begin
            bld_left[bld_count]   = l;
            bld_right[bld_count]  = r;
            bld_height[bld_count] = h;
            bld_count++;
        end
        else
            ovf_seen = 1;
        if (!last)
            return;
        build_tree(0, bld_count - 1);
        prev_h    = 0;
        first_new = skyline_q.size();
        for (int p = 0; p < 2 * bld_count; p++)
        begin
            if (pt_h[p] != prev_h)
            begin
                prev_h  = pt_h[p];
                kp.x    = pt_x[p];
                kp.h    = pt_h[p];
                kp.last = 0;
                kp.ovf  = ovf_seen;
                skyline_q.push_back(kp);
            end
        end
        if (skyline_q.size() > first_new)
            skyline_q[$].last = 1;
        groups_done++;
        if (ovf_seen)
            overflow_groups++;
        bld_count = 0;
        ovf_seen  = 0;
    endfunction

    function void check_point(bit [15:0] x, bit [15:0] h, bit lp, bit ov);
        key_point_t kp;
        points_checked++;
        if (skyline_q.size() == 0)
        begin
            $display("%0t: unexpected point x=%0d h=%0d last=%0b ovf=%0b",
                     $time, x, h, lp, ov);
            errors++;
            return;
        end
        kp = skyline_q.pop_front();
        if (x != kp.x)
        begin
            $display("%0t: point_x expected %0d actual %0d", $time, kp.x, x);
            errors++;
        end
        if (h != kp.h)
        begin
            $display("%0t: point_height expected %0d actual %0d", $time, kp.h, h);
            errors++;
        end
        if (lp != kp.last)
        begin
            $display("%0t: last_point expected %0b actual %0b", $time, kp.last, lp);
            errors++;
        end
        if (ov != kp.ovf)
        begin
            $display("%0t: overflow expected %0b actual %0b", $time, kp.ovf, ov);
            errors++;
        end
    endfunction
endclass

module skyline_merge_engine_top_test
    import skm_pkg::*;
;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 600;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [PORT_BITS-1:0]   building_left;
    logic [PORT_BITS-1:0]   building_right;
    logic [HEIGHT_BITS-1:0] building_height;
    logic                   last_building;
    logic                   out_valid;
    logic                   out_ready;
    logic [PORT_BITS-1:0]   point_x;
    logic [HEIGHT_BITS-1:0] point_height;
    logic                   last_point;
    logic                   overflow;

    skyline_scoreboard skyline_sb;
    int                cycle_count;
    int                buildings_sent;
    bit                no_gaps;      // stretch without sender idling
    bit                drain_no_gaps; // stretch without receiver stalls

    skyline_merge_engine_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .building_left   (building_left),
        .building_right  (building_right),
        .building_height (building_height),
        .last_building   (last_building),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .point_x         (point_x),
        .point_height    (point_height),
        .last_point      (last_point),
        .overflow        (overflow)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d points outstanding", $time, skyline_sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one building transfer; the valid line is touched once per falling edge
    task automatic send_building(bit [15:0] l, bit [15:0] r, bit [15:0] h, bit last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        building_left   <= l;
        building_right  <= r;
        building_height <= h;
        last_building   <= last;
        in_valid        <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        skyline_sb.note_building(l, r, h, last);
        buildings_sent++;
        @(negedge clk);
    endtask

    // a random group; narrow groups crowd the coordinates to force ties and overlaps
    task automatic send_group(int n, bit narrow);
        bit [15:0] l;
        bit [15:0] r;
        bit [15:0] h;
        for (int i = 0; i < n; i++)
        begin
            if (narrow)
            begin
                l = 16'($urandom_range(0, 40));
                r = ($urandom_range(0, 9) == 0) ? 16'(l - $urandom_range(0, 5))
                                                 : 16'(l + $urandom_range(0, 20));
                h = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
            end
            else
            begin
                l = 16'($urandom);
                r = 16'($urandom);
                h = 16'($urandom);
            end
            send_building(l, r, h, i == n - 1);
        end
    endtask

    // receiver: random stalls, one long hold-off so the block backs up its input
    initial
    begin : receiver
        int gap;
        int transfers;
        transfers = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (transfers == 40)
                gap = LONG_HOLD;
            else if (drain_no_gaps)
                gap = 0;
            else
                gap = $urandom_range(0, 14);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            skyline_sb.check_point(point_x, point_height, last_point, overflow);
            transfers++;
            @(negedge clk);
        end
    end

    initial
    begin : sender
        int settle;
        skyline_sb      = new();
        cycle_count     = 0;
        buildings_sent  = 0;
        no_gaps         = 0;
        drain_no_gaps   = 0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        building_left   = '0;
        building_right  = '0;
        building_height = '0;
        last_building   = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extreme single building, empty skyline, reversed edges,
        // all-zero heights, equal x ties, then a group beyond capacity
        send_building(16'hffff, 16'hffff, 16'hffff, 1'b1);
        send_building(16'h0000, 16'hffff, 16'h0000, 1'b1);
        send_building(16'd500, 16'd100, 16'd7, 1'b0);
        send_building(16'd50, 16'd20, 16'd9, 1'b1);
        send_building(16'd1, 16'd5, 16'd0, 1'b0);
        send_building(16'd2, 16'd6, 16'd0, 1'b1);
        send_building(16'd10, 16'd20, 16'd5, 1'b0);
        send_building(16'd10, 16'd20, 16'd5, 1'b0);
        send_building(16'd20, 16'd30, 16'd5, 1'b1);
        for (int i = 0; i < 17; i++)
            send_building(16'(i * 3), 16'(i * 3 + 4), 16'(i + 1), i == 16);

        // sender goes idle and waits for a full drain before the random groups
        in_valid <= 1'b0;
        while (skyline_sb.pending() != 0)
            @(negedge clk);

        while (buildings_sent < 410)
        begin
            no_gaps       = ($urandom_range(0, 3) == 0);
            drain_no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       send_group($urandom_range(16, 19), $urandom_range(0, 1));
                1, 2:    send_group($urandom_range(1, 8), 1'b0);
                default: send_group($urandom_range(1, 8), 1'b1);
            endcase
        end
        in_valid <= 1'b0;

        settle = 0;
        while (skyline_sb.pending() != 0 && settle < 200000)
        begin
            @(negedge clk);
            settle++;
        end
        repeat (1000) @(negedge clk);

        $display("covered %0d buildings in %0d groups (%0d over capacity), %0d points checked",
                 buildings_sent, skyline_sb.groups_done, skyline_sb.overflow_groups,
                 skyline_sb.points_checked);
        if (skyline_sb.errors == 0 && skyline_sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches, %0d points never arrived",
                     skyline_sb.errors, skyline_sb.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

[skyline_merge_engine_top.f]
sv/skm_pkg.sv
sv/skm_sched.sv
sv/skyline_merge_engine_top.sv
verif/skyline_merge_engine_top_test.sv
